// ----- src/priority_collection_engine_macros.svh -----
// Assertion macros shared by the priority collection engine RTL
`ifndef PRIORITY_COLLECTION_ENGINE_MACROS_SVH
`define PRIORITY_COLLECTION_ENGINE_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define PCE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define PCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/pce_pkg.sv -----
// Shared types and constants for the priority collection engine
package pce_pkg;

    // Fixed field widths
    localparam int ID_W  = 6;
    localparam int REQ_W = 3;
    localparam int ST_W  = 3;

    // Parameter defaults
    localparam int DEF_CAPACITY      = 64;
    localparam int DEF_PAYLOAD_WIDTH = 32;
    localparam int DEF_PRIO_WIDTH    = 16;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_ADD      = 3'd0,
        REQ_IS_VALID = 3'd1,
        REQ_GET      = 3'd2,
        REQ_PROMOTE  = 3'd3,
        REQ_GET_MAX  = 3'd4,
        REQ_POP_MAX  = 3'd5
    } t_req;

    // Status codes
    typedef enum logic [ST_W-1:0] {
        STS_OK      = 3'd0,
        STS_FULL    = 3'd1,
        STS_EMPTY   = 3'd2,
        STS_INVALID = 3'd3,
        STS_SAT     = 3'd4
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_PICK,
        S_FETCH
    } t_state;

endpackage

// ----- src/priority_collection_engine.sv -----
// Priority collection engine: fixed-capacity store with promote and max search
// Add, is_valid and errors are answered from the decode state; get and promote go on to the fetch
// state; get_max and pop_max scan every entry, then pass through pick and fetch (pick only when empty).
// A new request is accepted only in the idle state; a result held by the sink delays the next.
// The max search walks the priority RAM through its single read port, one entry a cycle.
// Synchronous active-low reset empties the store and restarts ids at zero.
`include "priority_collection_engine_macros.svh"

module priority_collection_engine #(
    parameter int CAPACITY      = pce_pkg::DEF_CAPACITY,
    parameter int PAYLOAD_WIDTH = pce_pkg::DEF_PAYLOAD_WIDTH,
    parameter int PRIO_WIDTH    = pce_pkg::DEF_PRIO_WIDTH,
    localparam int IN_TDATA_W   = ((pce_pkg::ID_W + PAYLOAD_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W  =
        ((pce_pkg::ID_W + PAYLOAD_WIDTH + PRIO_WIDTH + 1 + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Request channel
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [IN_TDATA_W-1:0]       i_s_tdata,  // target_id, payload_in, zero pad
    input  logic [pce_pkg::REQ_W-1:0]   i_s_tuser,  // req_type
    // Result channel
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,  // result_id, payload_out,
                                                    // priority_out, is_live, zero pad
    output logic [pce_pkg::ST_W-1:0]    o_m_tuser   // status
);

    import pce_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Sequencer and request registers
    t_state                  r_state, n_state;
    t_req                    r_req;
    logic [ID_W-1:0]         r_tid;
    logic [PAYLOAD_WIDTH-1:0] r_pin;

    // Store bookkeeping
    logic [CAPACITY-1:0]     r_live, n_live;
    logic [CNT_W-1:0]        r_next_id;

    // Scan registers
    logic [CNT_W-1:0]        r_scan;
    logic                    r_cmp_valid;
    logic [IDX_W-1:0]        r_cmp_idx;
    logic                    r_best_valid;
    logic [PRIO_WIDTH-1:0]   r_best_prio;
    logic [IDX_W-1:0]        r_idx;

    // Output register
    logic                    r_out_valid;
    t_status                 r_status, n_status;
    logic [ID_W-1:0]         r_result_id, n_result_id;
    logic [PAYLOAD_WIDTH-1:0] r_payload_out, n_payload_out;
    logic [PRIO_WIDTH-1:0]   r_priority_out, n_priority_out;
    logic                    r_is_live, n_is_live;

    // Strobes from the output decode
    logic                    w_emit;
    logic                    w_add_wr;
    logic                    w_prio_inc;
    logic                    w_live_clr;

    // Derived values
    logic                    w_out_free;
    logic                    w_accept;
    logic [31:0]             w_tid_ext;
    logic [IDX_W-1:0]        w_tid_idx;
    logic                    w_tid_live;
    logic [31:0]             w_idx_ext;
    logic [ID_W-1:0]         w_idx_id;
    logic [31:0]             w_next_ext;
    logic [ID_W-1:0]         w_next_id;
    logic [IDX_W-1:0]        w_next_idx;
    logic                    w_full;
    logic                    w_cmp_take;

    // RAM ports
    logic [IDX_W-1:0]        w_rd_addr;
    logic [PAYLOAD_WIDTH-1:0] w_pay_rd;
    logic [PRIO_WIDTH-1:0]   w_prio_rd;
    logic                    w_prio_wr_en;
    logic [IDX_W-1:0]        w_prio_wr_addr;
    logic [PRIO_WIDTH-1:0]   w_prio_wr_data;
    logic                    w_prio_max;

    // Handshake and id arithmetic
    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_tid_ext  = 32'(r_tid);
    assign w_tid_idx  = w_tid_ext[IDX_W-1:0];
    assign w_tid_live = (w_tid_ext < 32'(CAPACITY)) && r_live[w_tid_idx];
    assign w_idx_ext  = 32'(r_idx);
    assign w_idx_id   = w_idx_ext[ID_W-1:0];
    assign w_next_ext = 32'(r_next_id);
    assign w_next_id  = w_next_ext[ID_W-1:0];
    assign w_next_idx = r_next_id[IDX_W-1:0];
    assign w_full     = (r_next_id >= CAP_CNT);
    assign w_prio_max = &w_prio_rd;

    // Compare the entry read in the previous scan cycle against the best so far
    assign w_cmp_take = (r_state == S_SCAN) && r_cmp_valid && r_live[r_cmp_idx]
                        && (!r_best_valid || (w_prio_rd >= r_best_prio));

    // Select the shared read address
    always_comb begin
        unique case (r_state)
            S_DECODE: w_rd_addr = w_tid_idx;
            S_SCAN:   w_rd_addr = r_scan[IDX_W-1:0];
            default:  w_rd_addr = r_idx;
        endcase
    end

    // Priority RAM write: zero on add, increment on promote
    assign w_prio_wr_en   = w_add_wr || w_prio_inc;
    assign w_prio_wr_addr = w_add_wr ? w_next_idx : r_idx;
    assign w_prio_wr_data = w_add_wr ? '0 : w_prio_rd + PRIO_WIDTH'(1);

    pce_ram #(
        .WIDTH (PAYLOAD_WIDTH),
        .DEPTH (CAPACITY)
    ) u_payload_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_add_wr),
        .i_wr_addr (w_next_idx),
        .i_wr_data (r_pin),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_pay_rd)
    );

    pce_ram #(
        .WIDTH (PRIO_WIDTH),
        .DEPTH (CAPACITY)
    ) u_prio_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_prio_wr_en),
        .i_wr_addr (w_prio_wr_addr),
        .i_wr_data (w_prio_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_prio_rd)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_DECODE;
            end
            S_DECODE: begin
                priority case (1'b1)
                    (r_req == REQ_GET_MAX) || (r_req == REQ_POP_MAX): n_state = S_SCAN;
                    ((r_req == REQ_GET) || (r_req == REQ_PROMOTE)) && w_tid_live:
                        n_state = S_FETCH;
                    w_out_free: n_state = S_IDLE;
                    default: n_state = S_DECODE;
                endcase
            end
            S_SCAN: begin
                if (r_scan == CAP_CNT) n_state = S_PICK;
            end
            S_PICK: begin
                if (r_best_valid) begin
                    n_state = S_FETCH;
                end else if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_FETCH: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Result fields and side-effect strobes
    always_comb begin
        w_emit         = 1'b0;
        w_add_wr       = 1'b0;
        w_prio_inc     = 1'b0;
        w_live_clr     = 1'b0;
        n_status       = STS_OK;
        n_result_id    = '0;
        n_payload_out  = '0;
        n_priority_out = '0;
        n_is_live      = 1'b0;
        unique case (r_state)
            S_DECODE: begin
                unique case (r_req)
                    REQ_ADD: begin
                        w_emit = w_out_free;
                        if (w_full) begin
                            n_status = STS_FULL;
                        end else begin
                            w_add_wr      = w_out_free;
                            n_result_id   = w_next_id;
                            n_payload_out = r_pin;
                            n_is_live     = 1'b1;
                        end
                    end
                    REQ_IS_VALID: begin
                        w_emit      = w_out_free;
                        n_result_id = r_tid;
                        n_is_live   = w_tid_live;
                    end
                    REQ_GET, REQ_PROMOTE: begin
                        w_emit      = w_out_free && !w_tid_live;
                        n_status    = STS_INVALID;
                        n_result_id = r_tid;
                    end
                    REQ_GET_MAX, REQ_POP_MAX: begin
                        w_emit = 1'b0;
                    end
                    default: begin
                        w_emit   = w_out_free;
                        n_status = STS_INVALID;
                    end
                endcase
            end
            S_PICK: begin
                w_emit   = w_out_free && !r_best_valid;
                n_status = STS_EMPTY;
            end
            S_FETCH: begin
                w_emit         = w_out_free;
                n_result_id    = w_idx_id;
                n_payload_out  = w_pay_rd;
                n_priority_out = w_prio_rd;
                n_is_live      = 1'b1;
                unique case (r_req)
                    REQ_PROMOTE: begin
                        if (w_prio_max) begin
                            n_status = STS_SAT;
                        end else begin
                            w_prio_inc     = w_out_free;
                            n_priority_out = w_prio_rd + PRIO_WIDTH'(1);
                        end
                    end
                    REQ_POP_MAX: begin
                        w_live_clr = w_out_free;
                        n_is_live  = 1'b0;
                    end
                    default: begin
                        n_status = STS_OK;
                    end
                endcase
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // Live bit updates
    always_comb begin
        n_live = r_live;
        if (w_add_wr) n_live[w_next_idx] = 1'b1;
        if (w_live_clr) n_live[r_idx] = 1'b0;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_live       <= '0;
            r_next_id    <= '0;
            r_out_valid  <= 1'b0;
            r_scan       <= '0;
            r_cmp_valid  <= 1'b0;
            r_best_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_live  <= n_live;
            if (w_add_wr) r_next_id <= r_next_id + CNT_W'(1);
            // Hold the result until it is taken
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            // Step the scan
            if (r_state == S_DECODE) begin
                r_scan       <= '0;
                r_cmp_valid  <= 1'b0;
                r_best_valid <= 1'b0;
            end else if (r_state == S_SCAN) begin
                if (r_scan < CAP_CNT) begin
                    r_scan      <= r_scan + CNT_W'(1);
                    r_cmp_valid <= 1'b1;
                end else begin
                    r_cmp_valid <= 1'b0;
                end
                if (w_cmp_take) r_best_valid <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= t_req'(i_s_tuser);
            r_tid <= i_s_tdata[ID_W-1:0];
            r_pin <= i_s_tdata[ID_W +: PAYLOAD_WIDTH];
        end
        if (r_state == S_DECODE) r_idx <= w_tid_idx;
        if (r_state == S_SCAN) r_cmp_idx <= r_scan[IDX_W-1:0];
        if (w_cmp_take) begin
            r_best_prio <= w_prio_rd;
            r_idx       <= r_cmp_idx;
        end
        if (w_emit) begin
            r_status       <= n_status;
            r_result_id    <= n_result_id;
            r_payload_out  <= n_payload_out;
            r_priority_out <= n_priority_out;
            r_is_live      <= n_is_live;
        end
    end

    // Drive the result channel
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = OUT_TDATA_W'({r_is_live, r_priority_out, r_payload_out, r_result_id});

    // Checks
    `PCE_ASSERT_SAME(a_next_id_bound, i_clk, i_rst_n, 1'b1, r_next_id <= CAP_CNT,
        "issued id count exceeds capacity")
    `PCE_ASSERT_SAME(a_scan_bound, i_clk, i_rst_n, 1'b1, r_scan <= CAP_CNT,
        "scan counter ran past capacity")
    `PCE_ASSERT_NEXT(a_add_counts, i_clk, i_rst_n, w_add_wr,
        r_next_id == $past(r_next_id) + CNT_W'(1), "add did not advance the id count")
    `PCE_ASSERT_NEXT(a_pop_clears, i_clk, i_rst_n, w_live_clr,
        r_live[$past(r_idx)] == 1'b0, "pop left the entry live")
    `PCE_ASSERT_SAME(a_emit_free, i_clk, i_rst_n, w_emit, w_out_free,
        "result written over one not yet taken")

endmodule

// ----- src/pce_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module pce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- test/tb_priority_collection_engine.sv -----
// Self-checking testbench for the priority collection engine: stream stimulus, predictor, checker
module tb_priority_collection_engine;
    import pce_pkg::*;

    localparam int CAP      = DEF_CAPACITY;
    localparam int PW       = DEF_PAYLOAD_WIDTH;
    localparam int PRW      = DEF_PRIO_WIDTH;
    localparam int IN_W     = ((ID_W + PW + 7) / 8) * 8;
    localparam int OUT_W    = ((ID_W + PW + PRW + 1 + 7) / 8) * 8;
    localparam logic [PRW-1:0] PRIO_TOP = {PRW{1'b1}};
    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;
    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int HOLD_AT      = 3000;
    localparam int HOLD_LEN     = 400;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [REQ_W-1:0] kind;
        logic [ID_W-1:0]  tid;
        logic [PW-1:0]    data;
        bit               after_drain;
    } t_tb_req;

    typedef struct {
        t_status          status;
        logic [ID_W-1:0]  rid;
        logic [PW-1:0]    payload;
        logic [PRW-1:0]   prio;
        logic             live;
    } t_tb_resp;

    // Clock, reset and block ports
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;   // target_id, payload_in, zero pad
    logic [REQ_W-1:0]  s_tuser = '0;   // req_type
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;        // result_id, payload_out, priority_out, is_live, pad
    logic [ST_W-1:0]   m_tuser;        // status

    // Testbench state
    t_tb_req   pending_reqs[$];
    t_tb_resp  expected_resps[$];
    t_tb_req   offered;
    int        in_flight = 0;
    int        burst_left = 1;
    int        gap_left = 0;
    int        fail_count = 0;
    int        rx_cyc = 0;
    int        cyc_count = 0;
    int        gen_issued = 0;

    // Shadow of the collection
    logic [PW-1:0]  shadow_payload[CAP];
    logic [PRW-1:0] shadow_prio[CAP];
    bit             shadow_live[CAP];
    int             ids_issued = 0;

    priority_collection_engine uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Compute the response to one request and advance the shadow collection
    function automatic t_tb_resp apply_request(t_tb_req rq);
        t_tb_resp r;
        int best;
        r = '{STS_OK, '0, '0, '0, 1'b0};
        case (rq.kind)
            REQ_ADD: begin
                if (ids_issued >= CAP) begin
                    r.status = STS_FULL;
                end else begin
                    shadow_payload[ids_issued] = rq.data;
                    shadow_prio[ids_issued] = '0;
                    shadow_live[ids_issued] = 1'b1;
                    r.rid = ID_W'(ids_issued);
                    r.payload = rq.data;
                    r.live = 1'b1;
                    ids_issued++;
                end
            end
            REQ_IS_VALID: begin
                r.rid = rq.tid;
                r.live = shadow_live[rq.tid];
            end
            REQ_GET, REQ_PROMOTE: begin
                r.rid = rq.tid;
                if (!shadow_live[rq.tid]) begin
                    r.status = STS_INVALID;
                end else begin
                    if (rq.kind == REQ_PROMOTE) begin
                        if (shadow_prio[rq.tid] == PRIO_TOP)
                            r.status = STS_SAT;
                        else
                            shadow_prio[rq.tid]++;
                    end
                    r.payload = shadow_payload[rq.tid];
                    r.prio = shadow_prio[rq.tid];
                    r.live = 1'b1;
                end
            end
            REQ_GET_MAX, REQ_POP_MAX: begin
                // Ties go to the larger id, hence >=
                best = -1;
                for (int i = 0; i < CAP; i++) begin
                    if (shadow_live[i] && (best < 0 || shadow_prio[i] >= shadow_prio[best]))
                        best = i;
                end
                if (best < 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    r.rid = ID_W'(best);
                    r.payload = shadow_payload[best];
                    r.prio = shadow_prio[best];
                    r.live = (rq.kind == REQ_GET_MAX);
                    if (rq.kind == REQ_POP_MAX)
                        shadow_live[best] = 1'b0;
                end
            end
            default: begin
                r.status = STS_INVALID;
            end
        endcase
        return r;
    endfunction

    function automatic void flag_mismatch(string what, longint unsigned want,
                                          longint unsigned got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch in %s: expected 0x%0h, actual 0x%0h", what, want, got);
    endfunction

    task automatic queue_req(logic [REQ_W-1:0] kind, logic [ID_W-1:0] tid,
                             logic [PW-1:0] data, bit after_drain = 1'b0);
        t_tb_req item;
        item = '{kind, tid, data, after_drain};
        pending_reqs.insert(pending_reqs.size(), item);
    endtask

    // Drive requests in bursts; predict on every accepted transaction
    always @(posedge i_clk) begin
        bit took;
        bit got;
        took = s_tvalid && s_tready;
        got = m_tvalid && m_tready;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (took)
                expected_resps.insert(expected_resps.size(), apply_request(offered));
            in_flight = in_flight + int'(took) - int'(got);
            if (!s_tvalid || took) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0 &&
                             (!pending_reqs[0].after_drain || in_flight == 0)) begin
                    offered = pending_reqs.pop_front();
                    s_tdata <= {{(IN_W-ID_W-PW){1'b0}}, offered.data, offered.tid};
                    s_tuser <= offered.kind;
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern, with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_cyc <= 0;
        end else begin
            rx_cyc <= rx_cyc + 1;
            if (rx_cyc >= HOLD_AT && rx_cyc < HOLD_AT + HOLD_LEN) begin
                m_tready <= 1'b0;
            end else begin
                case (rx_cyc[10:9])
                    2'd0: m_tready <= 1'b1;
                    2'd1: m_tready <= (rx_cyc % 7) != 3;
                    2'd2: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= (rx_cyc % 23) < 15;
                endcase
            end
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_tb_resp want;
        t_tb_resp seen;
        if (i_rst_n && m_tvalid && m_tready) begin
            seen.status = t_status'(m_tuser);
            seen.rid = m_tdata[ID_W-1:0];
            seen.payload = m_tdata[ID_W +: PW];
            seen.prio = m_tdata[ID_W+PW +: PRW];
            seen.live = m_tdata[ID_W+PW+PRW];
            if (expected_resps.size() == 0) begin
                flag_mismatch("unexpected result status", 0, seen.status);
            end else begin
                want = expected_resps.pop_front();
                if (seen.status !== want.status)
                    flag_mismatch("status", want.status, seen.status);
                if (seen.rid !== want.rid)
                    flag_mismatch("result_id", want.rid, seen.rid);
                if (seen.payload !== want.payload)
                    flag_mismatch("payload_out", want.payload, seen.payload);
                if (seen.prio !== want.prio)
                    flag_mismatch("priority_out", want.prio, seen.prio);
                if (seen.live !== want.live)
                    flag_mismatch("is_live", want.live, seen.live);
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cyc_count <= cyc_count + 1;
        if (cyc_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int pick;
        logic [ID_W-1:0] tid;
        logic [PW-1:0] data;

        // Empty collection, never-issued ids and unknown requests
        queue_req(REQ_GET_MAX, 6'd0, '0);
        queue_req(REQ_POP_MAX, 6'd63, '1);
        queue_req(REQ_IS_VALID, 6'd0, '0);
        queue_req(REQ_GET, 6'd5, '0);
        queue_req(REQ_PROMOTE, 6'd63, '0);
        queue_req(REQ_UNUSED_LO, 6'd63, '1);
        queue_req(REQ_UNUSED_HI, 6'd21, 32'hA5A5_5A5A);
        // First adds; ties at zero go to the largest id
        queue_req(REQ_ADD, 6'd0, '0);
        queue_req(REQ_ADD, 6'd63, '1);
        queue_req(REQ_ADD, 6'd42, 32'h5A5A_A5A5);
        queue_req(REQ_IS_VALID, 6'd1, '0);
        queue_req(REQ_GET, 6'd1, '0);
        queue_req(REQ_GET_MAX, 6'd0, '0);
        queue_req(REQ_PROMOTE, 6'd0, '0);
        queue_req(REQ_GET_MAX, 6'd0, '0);
        // Raise id 1 above the other entries
        for (int i = 0; i < 5; i++)
            queue_req(REQ_PROMOTE, 6'd1, $urandom);
        queue_req(REQ_GET, 6'd1, '0);
        queue_req(REQ_GET_MAX, 6'd0, '0);
        // Pop the top entry, then touch it again
        queue_req(REQ_POP_MAX, 6'd0, '0);
        queue_req(REQ_GET, 6'd1, '0);
        queue_req(REQ_PROMOTE, 6'd1, '0);
        queue_req(REQ_IS_VALID, 6'd1, '0);
        queue_req(REQ_POP_MAX, 6'd0, '0);
        queue_req(REQ_POP_MAX, 6'd0, '0);
        queue_req(REQ_GET_MAX, 6'd0, '0);
        gen_issued = 3;

        // Random mix, biased toward ids that have been issued
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 85)
                tid = ID_W'($urandom_range(0, (gen_issued > 0) ? gen_issued - 1 : 0));
            else
                tid = ID_W'($urandom_range(0, CAP - 1));
            case ($urandom_range(0, 7))
                0: data = '0;
                1: data = '1;
                default: data = $urandom;
            endcase
            if (pick < 17) begin
                queue_req(REQ_ADD, tid, data, n == 600 || n == 1200);
                if (gen_issued < CAP)
                    gen_issued++;
            end else if (pick < 27) begin
                queue_req(REQ_IS_VALID, tid, data, n == 600 || n == 1200);
            end else if (pick < 42) begin
                queue_req(REQ_GET, tid, data, n == 600 || n == 1200);
            end else if (pick < 85) begin
                queue_req(REQ_PROMOTE, tid, data, n == 600 || n == 1200);
            end else if (pick < 94) begin
                queue_req(REQ_GET_MAX, tid, data, n == 600 || n == 1200);
            end else if (pick < 97) begin
                queue_req(REQ_POP_MAX, tid, data, n == 600 || n == 1200);
            end else begin
                queue_req(pick[0] ? REQ_UNUSED_HI : REQ_UNUSED_LO, tid, data,
                          n == 600 || n == 1200);
            end
        end

        // Hold reset, then let the stream run dry
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_reqs.size() > 0 || s_tvalid || in_flight > 0)
            @(posedge i_clk);
        repeat (CAP + 10) @(posedge i_clk);
        fail_count += expected_resps.size();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/pce_pkg.sv
src/pce_ram.sv
src/priority_collection_engine.sv
test/tb_priority_collection_engine.sv
